// ----- src/cau_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

    // operation codes carried in tuser
    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_MOD = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_SAT = 2'd2;

    localparam int IN_DATA_W  = 128;
    localparam int IN_USER_W  = 3;
    localparam int OUT_DATA_W = 72;

    // square root remainder and root widths (radicand is at most 64 bits)
    localparam int SQ_REM_W = 36;
    localparam int ROOT_W   = 32;

    typedef struct packed {
        logic [2:0] kind;
        logic       neg_re;
        logic       neg_im;
        logic       big_re;
        logic       big_im;
        logic       dz;
        logic       ovf;
    } t_ctl;

    typedef struct packed {
        logic [63:0]          d;
        logic [63:0]          rem_re;
        logic [63:0]          rem_im;
        logic [SQ_REM_W-1:0]  sq_rem;
        logic [ROOT_W-1:0]    sq_root;
        logic [63:0]          pre_re;
        logic [63:0]          pre_im;
    } t_fix;

endpackage

`default_nettype wire

// ----- src/cau_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cau_cell import cau_pkg::*; #(
    parameter int NC = 33
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  t_ctl            i_ctl,
    input  t_fix            i_fix,
    input  logic [NC-1:0]   i_num_re,
    input  logic [NC-1:0]   i_num_im,
    input  logic [NC-1:0]   i_q_re,
    input  logic [NC-1:0]   i_q_im,
    input  logic [2*NC-1:0] i_src,
    output logic            o_valid,
    output t_ctl            o_ctl,
    output t_fix            o_fix,
    output logic [NC-1:0]   o_num_re,
    output logic [NC-1:0]   o_num_im,
    output logic [NC-1:0]   o_q_re,
    output logic [NC-1:0]   o_q_im,
    output logic [2*NC-1:0] o_src
);

    logic [64:0]         w_sh_re;
    logic [64:0]         w_sh_im;
    logic                w_ge_re;
    logic                w_ge_im;
    logic [SQ_REM_W-1:0] w_sq_sh;
    logic [SQ_REM_W-1:0] w_trial;
    logic                w_sq_ge;
    t_fix                n_fix;

    logic                r_valid;
    t_ctl                r_ctl;
    t_fix                r_fix;
    logic [NC-1:0]       r_num_re;
    logic [NC-1:0]       r_num_im;
    logic [NC-1:0]       r_q_re;
    logic [NC-1:0]       r_q_im;
    logic [2*NC-1:0]     r_src;

    // one restoring divide step for each numerator, shared divisor
    assign w_sh_re = {i_fix.rem_re, i_num_re[NC-1]};
    assign w_sh_im = {i_fix.rem_im, i_num_im[NC-1]};
    assign w_ge_re = w_sh_re >= {1'b0, i_fix.d};
    assign w_ge_im = w_sh_im >= {1'b0, i_fix.d};

    // one digit of the integer square root
    assign w_sq_sh = {i_fix.sq_rem[SQ_REM_W-3:0], i_src[2*NC-1 -: 2]};
    assign w_trial = SQ_REM_W'({i_fix.sq_root, 2'b01});
    assign w_sq_ge = w_sq_sh >= w_trial;

    always_comb begin
        n_fix         = i_fix;
        n_fix.rem_re  = w_ge_re ? 64'(w_sh_re - {1'b0, i_fix.d}) : w_sh_re[63:0];
        n_fix.rem_im  = w_ge_im ? 64'(w_sh_im - {1'b0, i_fix.d}) : w_sh_im[63:0];
        n_fix.sq_rem  = w_sq_ge ? (w_sq_sh - w_trial) : w_sq_sh;
        n_fix.sq_root = {i_fix.sq_root[ROOT_W-2:0], w_sq_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl    <= i_ctl;
            r_fix    <= n_fix;
            r_num_re <= {i_num_re[NC-2:0], 1'b0};
            r_num_im <= {i_num_im[NC-2:0], 1'b0};
            r_q_re   <= {i_q_re[NC-2:0], w_ge_re};
            r_q_im   <= {i_q_im[NC-2:0], w_ge_im};
            r_src    <= {i_src[2*NC-3:0], 2'b00};
        end
    end

    assign o_valid  = r_valid;
    assign o_ctl    = r_ctl;
    assign o_fix    = r_fix;
    assign o_num_re = r_num_re;
    assign o_num_im = r_num_im;
    assign o_q_re   = r_q_re;
    assign o_q_im   = r_q_im;
    assign o_src    = r_src;

endmodule

`default_nettype wire

// ----- src/complex_arithmetic_unit_core.sv -----
// complex arithmetic unit: add, subtract, multiply, divide or modulus of
// complex operands in signed fixed point (Q16.16 at the defaults)
// input channel s_axis: tdata carries a_real, a_imag, b_real, b_imag, tuser
// carries the operation code; output channel m_axis: tdata carries
// res_real, res_imag and the status code
// every transaction in gives exactly one transaction out, in order
// stages: input register, products, numerators, chain setup, then
// NC = max(WORD_BITS + 1, 32) cells in the divide / square root chain
// and the output register; one transaction per cycle while the output is not stalled
// the chain makes one quotient bit of both parts and one root bit per cell
// reset clears all valid flags; no transaction is in flight afterwards
// when the receiver stalls, the output register holds and the pipeline
// freezes; the input stage still takes one transaction while it is empty

`timescale 1ns / 1ps
`default_nettype none

module complex_arithmetic_unit_core import cau_pkg::*; #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // a_real, a_imag, b_real, b_imag
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // kind
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata   // res_real, res_imag, status, zero pad
);

    localparam int NC = (WORD_BITS + 1 > ROOT_W) ? WORD_BITS + 1 : ROOT_W;
    localparam logic [63:0] LIM_POS = (64'd1 << (WORD_BITS - 1)) - 64'd1;
    localparam logic [63:0] LIM_NEG = 64'd1 << (WORD_BITS - 1);
    localparam logic [63:0] RND     = (64'd1 << FRAC_BITS) - 64'd1;
    localparam logic signed [63:0] SAT_MAX = $signed(LIM_POS);
    localparam logic signed [63:0] SAT_MIN = -$signed(LIM_NEG);

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

    function automatic logic [63:0] apply_sign(input logic n, input logic [63:0] m);
        return n ? (~m + 64'd1) : m;
    endfunction

    // sign-magnitude add, zero is always positive
    function automatic logic [64:0] sm_add(input logic n1, input logic [63:0] m1,
                                           input logic n2, input logic [63:0] m2);
        logic        n;
        logic [63:0] m;
        if (n1 == n2) begin
            n = n1;
            m = m1 + m2;
        end else if (m1 >= m2) begin
            n = n1;
            m = m1 - m2;
        end else begin
            n = n2;
            m = m2 - m1;
        end
        if (m == 64'd0) n = 1'b0;
        return {n, m};
    endfunction

    // clamp a magnitude to the word range, returns {overflow, value}
    function automatic logic [64:0] sat_mag(input logic n, input logic [63:0] q);
        logic [63:0] lim;
        lim = n ? LIM_NEG : LIM_POS;
        if (q > lim) return {1'b1, apply_sign(n, lim)};
        return {1'b0, apply_sign(n, q)};
    endfunction

    function automatic logic [64:0] sat_sum(input logic [32:0] s);
        logic signed [63:0] v;
        v = 64'($signed(s));
        if (v > SAT_MAX) return {1'b1, LIM_POS};
        if (v < SAT_MIN) return {1'b1, 64'(SAT_MIN)};
        return {1'b0, 64'(v)};
    endfunction

    // product shifted down with rounding toward minus infinity, then clamped
    function automatic logic [64:0] mul_res(input logic n, input logic [63:0] m);
        logic [64:0] t;
        t = n ? ({1'b0, m} + {1'b0, RND}) : {1'b0, m};
        return sat_mag(n, 64'(t >> FRAC_BITS));
    endfunction

    logic w_en;
    logic w_accept;

    // stage a: input register
    logic        r_a_valid;
    logic [2:0]  r_a_kind;
    logic [31:0] r_a_ar, r_a_ai, r_a_br, r_a_bi;

    // stage b: products
    logic [31:0] w_mar, w_mai, w_mbr, w_mbi, w_sx, w_sy;
    logic        r_b_valid;
    logic [2:0]  r_b_kind;
    logic [63:0] r_b_p1, r_b_p2, r_b_p3, r_b_p4, r_b_sq1, r_b_sq2;
    logic        r_b_s1, r_b_s2, r_b_s3, r_b_s4;
    logic [32:0] r_b_sum_re, r_b_sum_im;

    // stage c: numerators, divisor or radicand
    logic        r_c_valid;
    logic [2:0]  r_c_kind;
    logic        r_c_neg_re, r_c_neg_im;
    logic [63:0] r_c_m_re, r_c_m_im, r_c_q;
    logic [63:0] r_c_pre_re, r_c_pre_im;
    logic        r_c_ovf;
    logic [64:0] w_c_re, w_c_im, w_c_sre, w_c_sim;

    // stage d: chain setup
    logic [63+FRAC_BITS:0] w_nre, w_nim;
    logic [63:0]           w_hi_re, w_hi_im;
    logic [64:0]           w_mul_re, w_mul_im;
    t_ctl                  n_d_ctl;
    t_fix                  n_d_fix;
    logic                  r_d_valid;
    t_ctl                  r_d_ctl;
    t_fix                  r_d_fix;
    logic [NC-1:0]         r_d_num_re, r_d_num_im;
    logic [2*NC-1:0]       r_d_src;

    // cell chain
    logic            c_valid  [0:NC];
    t_ctl            c_ctl    [0:NC];
    t_fix            c_fix    [0:NC];
    logic [NC-1:0]   c_num_re [0:NC];
    logic [NC-1:0]   c_num_im [0:NC];
    logic [NC-1:0]   c_q_re   [0:NC];
    logic [NC-1:0]   c_q_im   [0:NC];
    logic [2*NC-1:0] c_src    [0:NC];

    // output stage
    t_ctl        w_e_ctl;
    t_fix        w_e_fix;
    logic [64:0] w_e_dre, w_e_dim, w_e_mod;
    logic [63:0] n_out_re, n_out_im;
    logic [1:0]  n_out_status;
    logic        r_out_valid;
    logic [31:0] r_out_re, r_out_im;
    logic [1:0]  r_out_status;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en || !r_a_valid;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_accept) begin
            r_a_valid <= 1'b1;
        end else if (w_en) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_kind <= s_axis_tuser;
            r_a_ar   <= s_axis_tdata[31:0];
            r_a_ai   <= s_axis_tdata[63:32];
            r_a_br   <= s_axis_tdata[95:64];
            r_a_bi   <= s_axis_tdata[127:96];
        end
    end

    assign w_mar = mag32(r_a_ar);
    assign w_mai = mag32(r_a_ai);
    assign w_mbr = mag32(r_a_br);
    assign w_mbi = mag32(r_a_bi);
    // the sum of squares serves as divisor or as radicand
    assign w_sx  = (r_a_kind == KIND_MOD) ? w_mar : w_mbr;
    assign w_sy  = (r_a_kind == KIND_MOD) ? w_mai : w_mbi;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_kind   <= r_a_kind;
            r_b_p1     <= w_mar * w_mbr;
            r_b_p2     <= w_mai * w_mbi;
            r_b_p3     <= w_mar * w_mbi;
            r_b_p4     <= w_mai * w_mbr;
            r_b_sq1    <= w_sx * w_sx;
            r_b_sq2    <= w_sy * w_sy;
            r_b_s1     <= r_a_ar[31] ^ r_a_br[31];
            r_b_s2     <= r_a_ai[31] ^ r_a_bi[31];
            r_b_s3     <= r_a_ar[31] ^ r_a_bi[31];
            r_b_s4     <= r_a_ai[31] ^ r_a_br[31];
            r_b_sum_re <= (r_a_kind == KIND_SUB) ? ({r_a_ar[31], r_a_ar} - {r_a_br[31], r_a_br})
                                                 : ({r_a_ar[31], r_a_ar} + {r_a_br[31], r_a_br});
            r_b_sum_im <= (r_a_kind == KIND_SUB) ? ({r_a_ai[31], r_a_ai} - {r_a_bi[31], r_a_bi})
                                                 : ({r_a_ai[31], r_a_ai} + {r_a_bi[31], r_a_bi});
        end
    end

    // multiply: re = ar*br - ai*bi, im = ar*bi + ai*br
    // divide:   re = ar*br + ai*bi, im = ai*br - ar*bi
    assign w_c_re  = sm_add(r_b_s1, r_b_p1, r_b_s2 ^ (r_b_kind == KIND_MUL), r_b_p2);
    assign w_c_im  = sm_add(r_b_s3 ^ (r_b_kind == KIND_DIV), r_b_p3, r_b_s4, r_b_p4);
    assign w_c_sre = sat_sum(r_b_sum_re);
    assign w_c_sim = sat_sum(r_b_sum_im);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_kind   <= r_b_kind;
            r_c_neg_re <= w_c_re[64];
            r_c_m_re   <= w_c_re[63:0];
            r_c_neg_im <= w_c_im[64];
            r_c_m_im   <= w_c_im[63:0];
            r_c_q      <= r_b_sq1 + r_b_sq2;
            r_c_pre_re <= w_c_sre[63:0];
            r_c_pre_im <= w_c_sim[63:0];
            r_c_ovf    <= w_c_sre[64] | w_c_sim[64];
        end
    end

    // quotient bits above NC mean the result is far out of range
    assign w_nre    = {r_c_m_re, {FRAC_BITS{1'b0}}};
    assign w_nim    = {r_c_m_im, {FRAC_BITS{1'b0}}};
    assign w_hi_re  = 64'(w_nre[63+FRAC_BITS:NC]);
    assign w_hi_im  = 64'(w_nim[63+FRAC_BITS:NC]);
    assign w_mul_re = mul_res(r_c_neg_re, r_c_m_re);
    assign w_mul_im = mul_res(r_c_neg_im, r_c_m_im);

    always_comb begin
        n_d_ctl.kind   = r_c_kind;
        n_d_ctl.neg_re = r_c_neg_re;
        n_d_ctl.neg_im = r_c_neg_im;
        n_d_ctl.big_re = w_hi_re >= r_c_q;
        n_d_ctl.big_im = w_hi_im >= r_c_q;
        n_d_ctl.dz     = (r_c_q == 64'd0);
        n_d_fix.d       = r_c_q;
        n_d_fix.rem_re  = w_hi_re;
        n_d_fix.rem_im  = w_hi_im;
        n_d_fix.sq_rem  = '0;
        n_d_fix.sq_root = '0;
        case (r_c_kind)
            KIND_ADD, KIND_SUB: begin
                n_d_fix.pre_re = r_c_pre_re;
                n_d_fix.pre_im = r_c_pre_im;
                n_d_ctl.ovf    = r_c_ovf;
            end
            KIND_MUL: begin
                n_d_fix.pre_re = w_mul_re[63:0];
                n_d_fix.pre_im = w_mul_im[63:0];
                n_d_ctl.ovf    = w_mul_re[64] | w_mul_im[64];
            end
            default: begin
                n_d_fix.pre_re = '0;
                n_d_fix.pre_im = '0;
                n_d_ctl.ovf    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (w_en) begin
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_ctl    <= n_d_ctl;
            r_d_fix    <= n_d_fix;
            r_d_num_re <= w_nre[NC-1:0];
            r_d_num_im <= w_nim[NC-1:0];
            r_d_src    <= (2*NC)'(r_c_q);
        end
    end

    assign c_valid[0]  = r_d_valid;
    assign c_ctl[0]    = r_d_ctl;
    assign c_fix[0]    = r_d_fix;
    assign c_num_re[0] = r_d_num_re;
    assign c_num_im[0] = r_d_num_im;
    assign c_q_re[0]   = '0;
    assign c_q_im[0]   = '0;
    assign c_src[0]    = r_d_src;

    for (genvar g = 0; g < NC; g++) begin : g_cell
        cau_cell #(
            .NC (NC)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_valid  (c_valid[g]),
            .i_ctl    (c_ctl[g]),
            .i_fix    (c_fix[g]),
            .i_num_re (c_num_re[g]),
            .i_num_im (c_num_im[g]),
            .i_q_re   (c_q_re[g]),
            .i_q_im   (c_q_im[g]),
            .i_src    (c_src[g]),
            .o_valid  (c_valid[g+1]),
            .o_ctl    (c_ctl[g+1]),
            .o_fix    (c_fix[g+1]),
            .o_num_re (c_num_re[g+1]),
            .o_num_im (c_num_im[g+1]),
            .o_q_re   (c_q_re[g+1]),
            .o_q_im   (c_q_im[g+1]),
            .o_src    (c_src[g+1])
        );
    end

    assign w_e_ctl = c_ctl[NC];
    assign w_e_fix = c_fix[NC];
    assign w_e_dre = sat_mag(w_e_ctl.neg_re, w_e_ctl.big_re ? '1 : 64'(c_q_re[NC]));
    assign w_e_dim = sat_mag(w_e_ctl.neg_im, w_e_ctl.big_im ? '1 : 64'(c_q_im[NC]));
    assign w_e_mod = sat_mag(1'b0, 64'(w_e_fix.sq_root));

    always_comb begin
        case (w_e_ctl.kind)
            KIND_ADD, KIND_SUB, KIND_MUL: begin
                n_out_re     = w_e_fix.pre_re;
                n_out_im     = w_e_fix.pre_im;
                n_out_status = w_e_ctl.ovf ? ST_SAT : ST_OK;
            end
            KIND_DIV: begin
                if (w_e_ctl.dz) begin
                    n_out_re     = '0;
                    n_out_im     = '0;
                    n_out_status = ST_DZ;
                end else begin
                    n_out_re     = w_e_dre[63:0];
                    n_out_im     = w_e_dim[63:0];
                    n_out_status = (w_e_dre[64] | w_e_dim[64]) ? ST_SAT : ST_OK;
                end
            end
            KIND_MOD: begin
                n_out_re     = w_e_mod[63:0];
                n_out_im     = '0;
                n_out_status = w_e_mod[64] ? ST_SAT : ST_OK;
            end
            default: begin
                n_out_re     = '0;
                n_out_im     = '0;
                n_out_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_re     <= n_out_re[31:0];
            r_out_im     <= n_out_im[31:0];
            r_out_status <= n_out_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b000000, r_out_status, r_out_im, r_out_re};

endmodule

`default_nettype wire

// ----- src/cau_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cau_checker import cau_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic [1:0] w_status;

    assign w_status = m_axis_tdata[65:64];

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_status == ST_OK || w_status == ST_DZ || w_status == ST_SAT))
        else $error("undefined status code");

    // divide by zero returns zero in both parts
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == ST_DZ) |-> (m_axis_tdata[63:0] == 64'd0))
        else $error("divide by zero result not zero");

    // with no result waiting the input is always open
    a_in_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input refused while output idle");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind complex_arithmetic_unit_core cau_checker u_cau_checker (.*);

`default_nettype wire

// ----- tb/tb_complex_arithmetic_unit_core.sv -----
`timescale 1ns / 1ps

module tb_complex_arithmetic_unit_core;
    import cau_pkg::*;

    localparam int FRAC = 16;
    localparam int WORD = 32;

    typedef struct {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  st;
    } cplx_res_t;

    class cau_scoreboard;
        cplx_res_t result_q[$];
        int        mismatches;

        function logic [31:0] clamp(input logic signed [127:0] v, inout bit ovf);
            logic signed [127:0] hi;
            logic signed [127:0] lo;
            hi = (128'sd1 <<< (WORD - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                ovf = 1'b1;
                v = hi;
            end else if (v < lo) begin
                ovf = 1'b1;
                v = lo;
            end
            return v[31:0];
        endfunction

        function cplx_res_t compute(input logic [2:0] kind, input logic signed [31:0] ar,
                                    input logic signed [31:0] ai,
                                    input logic signed [31:0] br,
                                    input logic signed [31:0] bi);
            cplx_res_t r;
            bit ovf;
            logic signed [127:0] xr, xi, yr, yi, d, nr, ni;
            logic [127:0] s, root, t;
            ovf = 1'b0;
            xr = ar;
            xi = ai;
            yr = br;
            yi = bi;
            r.re = '0;
            r.im = '0;
            r.st = ST_OK;
            case (kind)
                KIND_ADD: begin
                    r.re = clamp(xr + yr, ovf);
                    r.im = clamp(xi + yi, ovf);
                end
                KIND_SUB: begin
                    r.re = clamp(xr - yr, ovf);
                    r.im = clamp(xi - yi, ovf);
                end
                KIND_MUL: begin
                    // arithmetic shift floors
                    r.re = clamp((xr * yr - xi * yi) >>> FRAC, ovf);
                    r.im = clamp((xr * yi + xi * yr) >>> FRAC, ovf);
                end
                KIND_DIV: begin
                    d = yr * yr + yi * yi;
                    if (d == 0) begin
                        r.st = ST_DZ;
                    end else begin
                        nr = (xr * yr + xi * yi) <<< FRAC;
                        ni = (xi * yr - xr * yi) <<< FRAC;
                        // signed divide truncates toward zero
                        r.re = clamp(nr / d, ovf);
                        r.im = clamp(ni / d, ovf);
                    end
                end
                KIND_MOD: begin
                    s = xr * xr + xi * xi;
                    root = '0;
                    for (int b = 32; b >= 0; b--) begin
                        t = root | (128'd1 << b);
                        if (t * t <= s) root = t;
                    end
                    r.re = clamp($signed(root), ovf);
                end
                default: ;
            endcase
            if (r.st == ST_OK && ovf) r.st = ST_SAT;
            return r;
        endfunction

        function void note_operands(input logic [2:0] kind, input logic [127:0] data);
            result_q.push_back(compute(kind, data[31:0], data[63:32], data[95:64],
                                       data[127:96]));
        endfunction

        function void check_result(input logic [OUT_DATA_W-1:0] data);
            cplx_res_t e;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            e = result_q.pop_front();
            if (data[31:0] !== e.re || data[63:32] !== e.im || data[65:64] !== e.st) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected re %h im %h st %0d, got re %h im %h st %0d",
                             e.re, e.im, e.st, data[31:0], data[63:32], data[65:64]);
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // a_real, a_imag, b_real, b_imag
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;  // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;       // res_real, res_imag, status, zero pad

    cau_scoreboard sb = new();
    int idle_in = 0;
    int idle_out = 0;
    int hold_off = 0;

    complex_arithmetic_unit_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // receiver: check each transaction, then pick next ready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= idle_out);
        end
    end

    task automatic send_item(input logic [2:0] kind, input logic [31:0] ar,
                             input logic [31:0] ai, input logic [31:0] br,
                             input logic [31:0] bi);
        while ($urandom_range(99) < idle_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {bi, br, ai, ar};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_operands(kind, {bi, br, ai, ar});
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(1 << 18) - (1 << 17);
            2: return $urandom_range(1 << 25) - (1 << 24);
            3: begin
                case ($urandom_range(4))
                    0: return 32'h7fffffff;
                    1: return 32'h80000000;
                    2: return 32'h0;
                    3: return 32'h1;
                    default: return 32'hffffffff;
                endcase
            end
            default: return $urandom_range(1 << 20) - (1 << 19);
        endcase
    endfunction

    task automatic send_random(input int count);
        logic [2:0]  kind;
        logic [31:0] br, bi;
        for (int n = 0; n < count; n++) begin
            kind = ($urandom_range(19) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(4));
            br = pick_operand();
            bi = pick_operand();
            if (kind == KIND_DIV && $urandom_range(9) == 0) begin
                br = '0;
                bi = '0;
            end
            send_item(kind, pick_operand(), pick_operand(), br, bi);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        idle_in = 6;
        idle_out = 57;
        send_item(KIND_ADD, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        send_item(KIND_ADD, 32'h00010000, 32'hffff0000, 32'h00020000, 32'h00000001);
        send_item(KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        send_item(KIND_SUB, 32'h00050000, 32'h00000000, 32'h00010000, 32'h00030000);
        send_item(KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        send_item(KIND_MUL, 32'h00020000, 32'h00030000, 32'h00010000, 32'hffff0000);
        send_item(KIND_MUL, 32'hffffffff, 32'h00000001, 32'h00000001, 32'h00000001);
        send_item(KIND_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
        send_item(KIND_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
        send_item(KIND_DIV, 32'h00040000, 32'h00020000, 32'h00010000, 32'h00010000);
        send_item(KIND_DIV, 32'hfffe0000, 32'h00010000, 32'h80000000, 32'h7fffffff);
        send_item(KIND_MOD, 32'h80000000, 32'h80000000, 32'h12345678, 32'h9abcdef0);
        send_item(KIND_MOD, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
        send_item(KIND_MOD, 32'h0, 32'h0, 32'h0, 32'h0);
        send_item(3'd5, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
        send_item(3'd6, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_item(3'd7, 32'h7fffffff, 32'h80000000, 32'h0, 32'h1);

        send_random(430);
        idle_in = 57;
        idle_out = 6;
        send_random(430);
        idle_in = 0;
        idle_out = 0;
        // long receiver stall so the pipeline fills and backpressures
        hold_off = 200;
        send_random(430);
        s_axis_tvalid <= 1'b0;

        while (sb.result_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.result_q.size() == 0) begin
            $display("complex_arithmetic_unit_core test passed");
        end else begin
            $display("complex_arithmetic_unit_core test failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("complex_arithmetic_unit_core test failed");
        $finish;
    end

endmodule

// ----- complex_arithmetic_unit_core.f -----
src/cau_pkg.sv
src/cau_cell.sv
src/complex_arithmetic_unit_core.sv
src/cau_checker.sv
tb/tb_complex_arithmetic_unit_core.sv
